// ----- design/bqc_pkg.sv -----
// Package for the biquad coefficient calculator: fixed widths, CORDIC
// constants and the arctangent table. No dependencies.
`timescale 1ns / 1ps
package bqc_pkg;
	localparam int RATE_W = 18;
	localparam int PH_W = 32;
	localparam int WORK_FRAC = 30;
	localparam int XY_W = 34;
	localparam int OUT_W = 32;
	localparam logic signed [XY_W-1:0] INV_GAIN = 34'sd652032874;
	localparam logic signed [31:0] INV_TWO_Q = 32'sd759364798;

	function automatic logic [PH_W-1:0] atan_turn(input logic [4:0] i);
		logic [PH_W-1:0] v;
		begin
			case (i)
				5'd0: v = 32'h20000000;  5'd1: v = 32'h12E4051D;
				5'd2: v = 32'h09FB385B;  5'd3: v = 32'h051111D4;
				5'd4: v = 32'h028B0D43;  5'd5: v = 32'h0145D7E1;
				5'd6: v = 32'h00A2F61E;  5'd7: v = 32'h00517C55;
				5'd8: v = 32'h0028BE53;  5'd9: v = 32'h00145F2E;
				5'd10: v = 32'h000A2F98; 5'd11: v = 32'h000517CC;
				5'd12: v = 32'h00028BE6; 5'd13: v = 32'h000145F3;
				5'd14: v = 32'h0000A2F9; 5'd15: v = 32'h0000517C;
				5'd16: v = 32'h000028BE; 5'd17: v = 32'h0000145F;
				5'd18: v = 32'h00000A2F; 5'd19: v = 32'h00000517;
				5'd20: v = 32'h0000028B; 5'd21: v = 32'h00000145;
				5'd22: v = 32'h000000A2; 5'd23: v = 32'h00000051;
				5'd24: v = 32'h00000028; 5'd25: v = 32'h00000014;
				5'd26: v = 32'h0000000A; 5'd27: v = 32'h00000005;
				5'd28: v = 32'h00000002; 5'd29: v = 32'h00000001;
				default: v = 32'h0;
			endcase
			return v;
		end
	endfunction
endpackage

// ----- design/biquad_coefficient_calculator.sv -----
// Biquad coefficient calculator, cookbook low-pass/high-pass with Q = 0.707.
// Input channel: cutoff_freq, low_pass with in_valid/in_ready. Output channel:
// den0..2, num0..2 with out_valid/out_ready. The user must write sample_rate
// through cfg_we/cfg_wdata only while no item is in flight; the block does not enforce it.
// The datapath is a row of cells that all advance together: 18 + 32
// long-division cells (one quotient bit each; the first 18 reduce the cutoff
// modulo the rate), CORDIC_STAGES rotation cells, then a multiply stage and
// an output stage.
// Depth: 18 + 32 + CORDIC_STAGES + 2 = 76 register stages at default.
// Throughput: one item per cycle; the chain shifts every cycle in which the
// output register is empty or being taken.
// When the receiver stalls with a result waiting, the whole chain holds and
// in_ready drops in the same cycle.
// Reset empties the chain and sets sample_rate to 48000.
// Uses bqc_pkg, bqc_div_cell, bqc_cordic_cell.
`timescale 1ns / 1ps
module biquad_coefficient_calculator import bqc_pkg::*; #(
	parameter int FRAC_BITS = 28,
	parameter int CORDIC_STAGES = 24
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [RATE_W-1:0]       cfg_wdata,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [RATE_W-1:0]       cutoff_freq,
	input  logic                    low_pass,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [OUT_W-1:0] den0,
	output logic signed [OUT_W-1:0] den1,
	output logic signed [OUT_W-1:0] den2,
	output logic signed [OUT_W-1:0] num0,
	output logic signed [OUT_W-1:0] num1,
	output logic signed [OUT_W-1:0] num2
);
	localparam int DIV_N = RATE_W + PH_W;
	localparam int DEPTH = DIV_N + CORDIC_STAGES + 2;
	localparam int SH = WORK_FRAC - FRAC_BITS;

	logic [RATE_W-1:0] rate_q;
	logic [DEPTH-1:0]  vld_q;
	logic              adv;

	assign adv = !out_valid || out_ready;
	assign in_ready = adv;
	assign out_valid = vld_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= RATE_W'(48000);
			vld_q <= '0;
		end else begin
			if (cfg_we) rate_q <= cfg_wdata;
			if (adv) vld_q <= {vld_q[DEPTH-2:0], in_valid};
		end
	end

	// long division of cutoff * 2^32 by the rate; the last 32 quotient bits
	// are the turn fraction of (cutoff mod rate) / rate
	logic [RATE_W:0]   d_rem [DIV_N+1];
	logic [RATE_W-1:0] d_num [DIV_N+1];
	logic [PH_W-1:0]   d_quo [DIV_N+1];
	logic [RATE_W-1:0] d_den [DIV_N+1];
	logic              d_lp  [DIV_N+1];

	assign d_rem[0] = '0;
	assign d_num[0] = cutoff_freq;
	assign d_quo[0] = '0;
	assign d_den[0] = rate_q;
	assign d_lp[0] = low_pass;

	for (genvar k = 0; k < DIV_N; k++) begin : g_div
		bqc_div_cell u_cell (
			.clk(clk), .adv(adv), .den_in(d_den[k]), .rem_in(d_rem[k]),
			.num_in(d_num[k]), .quo_in(d_quo[k]), .lp_in(d_lp[k]),
			.den_q(d_den[k+1]), .rem_q(d_rem[k+1]), .num_q(d_num[k+1]),
			.quo_q(d_quo[k+1]), .lp_q(d_lp[k+1])
		);
	end

	// zero rate: quotient bits come out all ones, force phase to zero
	logic [PH_W-1:0] phase;
	logic [PH_W-1:0] ph_f;
	logic            flip;
	assign phase = (d_den[DIV_N] == '0) ? '0 : d_quo[DIV_N];
	assign flip = (phase[PH_W-1:PH_W-2] == 2'b01) || (phase[PH_W-1:PH_W-2] == 2'b10);
	assign ph_f = flip ? (phase - 32'h80000000) : phase;

	logic signed [XY_W-1:0] cx [CORDIC_STAGES+1];
	logic signed [XY_W-1:0] cy [CORDIC_STAGES+1];
	logic signed [PH_W:0]   cz [CORDIC_STAGES+1];
	logic                   cf [CORDIC_STAGES+1];
	logic                   cl [CORDIC_STAGES+1];

	assign cx[0] = INV_GAIN;
	assign cy[0] = '0;
	assign cz[0] = $signed({ph_f[PH_W-1], ph_f});
	assign cf[0] = flip;
	assign cl[0] = d_lp[DIV_N];

	for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cor
		bqc_cordic_cell #(.IDX(k)) u_cell (
			.clk(clk), .adv(adv), .x_in(cx[k]), .y_in(cy[k]), .z_in(cz[k]),
			.flip_in(cf[k]), .lp_in(cl[k]), .x_q(cx[k+1]), .y_q(cy[k+1]),
			.z_q(cz[k+1]), .flip_q(cf[k+1]), .lp_q(cl[k+1])
		);
	end

	// multiply stage: alpha = sin * 1/(2Q), rounded half up to Q30
	logic signed [XY_W-1:0] c_s1, s_fin;
	logic signed [XY_W+31:0] prod_s1;
	logic                   lp_s1;
	assign s_fin = cf[CORDIC_STAGES] ? -cy[CORDIC_STAGES] : cy[CORDIC_STAGES];

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s1 <= cf[CORDIC_STAGES] ? -cx[CORDIC_STAGES] : cx[CORDIC_STAGES];
			prod_s1 <= (XY_W+32)'(s_fin) * (XY_W+32)'(INV_TWO_Q);
			lp_s1 <= cl[CORDIC_STAGES];
		end
	end

	localparam logic signed [XY_W+1:0] ONE = (XY_W+2)'(1) <<< WORK_FRAC;
	logic signed [XY_W+31:0] prod_r;
	logic signed [XY_W+1:0]  alpha, c_w, n1, d0, d1, d2, n1o;
	assign prod_r = (prod_s1 + ((XY_W+32)'(1) <<< (WORK_FRAC-1))) >>> WORK_FRAC;
	assign alpha = prod_r[XY_W+1:0];
	assign c_w = (XY_W+2)'(c_s1);
	assign n1 = lp_s1 ? (ONE - c_w) : (ONE + c_w);
	assign d0 = ONE + alpha;
	assign d1 = -(c_w <<< 1);
	assign d2 = ONE - alpha;
	assign n1o = lp_s1 ? n1 : -n1;

	function automatic logic signed [OUT_W-1:0] rnd(input logic signed [XY_W+1:0] v,
		input int s);
		logic signed [XY_W+1:0] t;
		begin
			if (s == 0) t = v;
			else t = (v + ((XY_W+2)'(1) <<< (s-1))) >>> s;
			return t[OUT_W-1:0];
		end
	endfunction

	always_ff @(posedge clk) begin
		if (adv) begin
			den0 <= rnd(d0, SH);
			den1 <= rnd(d1, SH);
			den2 <= rnd(d2, SH);
			num0 <= rnd(n1, SH + 1);
			num1 <= rnd(n1o, SH);
			num2 <= rnd(n1, SH + 1);
		end
	end
endmodule

// ----- design/bqc_div_cell.sv -----
// One long-division cell: brings in one dividend bit and yields one quotient bit.
// Depends on bqc_pkg.
`timescale 1ns / 1ps
module bqc_div_cell import bqc_pkg::*; (
	input  logic              clk,
	input  logic              adv,
	input  logic [RATE_W-1:0] den_in,
	input  logic [RATE_W:0]   rem_in,
	input  logic [RATE_W-1:0] num_in,
	input  logic [PH_W-1:0]   quo_in,
	input  logic              lp_in,
	output logic [RATE_W-1:0] den_q,
	output logic [RATE_W:0]   rem_q,
	output logic [RATE_W-1:0] num_q,
	output logic [PH_W-1:0]   quo_q,
	output logic              lp_q
);
	logic [RATE_W+1:0] sh;
	logic [RATE_W+1:0] diff;
	logic              ge;

	// take the next dividend bit MSB first; zeros follow once it is used up
	assign sh = {rem_in, num_in[RATE_W-1]};
	assign diff = sh - {2'b00, den_in};
	assign ge = (sh >= {2'b00, den_in});

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_q <= ge ? diff[RATE_W:0] : sh[RATE_W:0];
			num_q <= {num_in[RATE_W-2:0], 1'b0};
			quo_q <= {quo_in[PH_W-2:0], ge};
			den_q <= den_in;
			lp_q <= lp_in;
		end
	end
endmodule

// ----- design/bqc_cordic_cell.sv -----
// One CORDIC rotation cell with a fixed shift and table angle.
// Depends on bqc_pkg.
`timescale 1ns / 1ps
module bqc_cordic_cell import bqc_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic                   clk,
	input  logic                   adv,
	input  logic signed [XY_W-1:0] x_in,
	input  logic signed [XY_W-1:0] y_in,
	input  logic signed [PH_W:0]   z_in,
	input  logic                   flip_in,
	input  logic                   lp_in,
	output logic signed [XY_W-1:0] x_q,
	output logic signed [XY_W-1:0] y_q,
	output logic signed [PH_W:0]   z_q,
	output logic                   flip_q,
	output logic                   lp_q
);
	localparam logic [PH_W:0] ANG = {1'b0, atan_turn(5'(IDX))};
	logic signed [XY_W-1:0] dx, dy;

	assign dx = y_in >>> IDX;
	assign dy = x_in >>> IDX;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (!z_in[PH_W]) begin
				x_q <= x_in - dx;
				y_q <= y_in + dy;
				z_q <= z_in - $signed(ANG);
			end else begin
				x_q <= x_in + dx;
				y_q <= y_in - dy;
				z_q <= z_in + $signed(ANG);
			end
			flip_q <= flip_in;
			lp_q <= lp_in;
		end
	end
endmodule

// ----- tb/sv/biquad_coefficient_calculator_tb.sv -----
// Testbench for the biquad coefficient calculator: drives cutoff items through
// the valid/ready channels and compares each coefficient set with a bit-exact
// in-bench predictor. Depends on bqc_pkg and biquad_coefficient_calculator.
`timescale 1ns / 1ps

typedef struct packed {
	logic signed [31:0] d0, d1, d2, n0, n1, n2;
} coeff_set_t;

class coeff_scoreboard;
	coeff_set_t pending[$];
	logic [17:0] rate;
	int mismatches;
	int checked;

	function new();
		rate = 18'd48000;
		mismatches = 0;
		checked = 0;
	endfunction

	static function longint shr_floor(longint v, int s);
		return v >>> s;
	endfunction

	static function longint shr_round(longint v, int s);
		if (s == 0) return v;
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	static function logic [31:0] atan_entry(int i);
		logic [31:0] t [0:31];
		t = '{32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
			32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
			32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
			32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
			32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
			32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
			32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
			32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000};
		return t[i];
	endfunction

	function void note_input(logic [17:0] cutoff, logic lp);
		logic [31:0] phase;
		logic [63:0] rem;
		logic [1:0] quad;
		bit flip;
		longint x, y, z, dx, dy, one, alpha, nsum;
		coeff_set_t e;
		phase = 0;
		one = longint'(1) <<< 30;
		if (rate != 0) begin
			rem = cutoff % rate;
			phase = 32'((rem << 32) / rate);
		end
		quad = phase[31:30];
		flip = (quad == 2'd1 || quad == 2'd2);
		if (flip) phase = phase - 32'h80000000;
		z = longint'($signed(phase));
		x = 652032874;
		y = 0;
		for (int i = 0; i < 24; i++) begin
			dx = shr_floor(y, i);
			dy = shr_floor(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(atan_entry(i));
			end else begin
				x += dx; y -= dy; z += longint'(atan_entry(i));
			end
		end
		if (flip) begin
			x = -x; y = -y;
		end
		alpha = shr_round(y * 759364798, 30);
		e.d0 = 32'(shr_round(one + alpha, 2));
		e.d1 = 32'(shr_round(-2 * x, 2));
		e.d2 = 32'(shr_round(one - alpha, 2));
		nsum = lp ? one - x : one + x;
		e.n0 = 32'(shr_round(nsum, 3));
		e.n1 = 32'(shr_round(lp ? nsum : -nsum, 2));
		e.n2 = e.n0;
		pending.push_back(e);
	endfunction

	function void check_result(coeff_set_t got);
		coeff_set_t e;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("unexpected coefficient set at %0t", $time);
			return;
		end
		e = pending.pop_front();
		checked++;
		if (got != e) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch at %0t: exp %h %h %h %h %h %h got %h %h %h %h %h %h",
					$time, e.d0, e.d1, e.d2, e.n0, e.n1, e.n2,
					got.d0, got.d1, got.d2, got.n0, got.n1, got.n2);
		end
	endfunction
endclass

module biquad_coefficient_calculator_tb;
	import bqc_pkg::*;

	localparam int LATENCY = 76;
	localparam int WATCHDOG = 20000;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [RATE_W-1:0] cfg_wdata = '0;
	logic in_valid = 0;
	logic in_ready;
	logic [RATE_W-1:0] cutoff_freq = '0;
	logic low_pass = 0;
	logic out_valid;
	logic out_ready = 0;
	logic signed [OUT_W-1:0] den0, den1, den2, num0, num1, num2;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_off = 0;
	int stalled_cycles = 0;
	int items_sent = 0;
	coeff_scoreboard sb;

	always #5 clk = ~clk;

	biquad_coefficient_calculator dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .cutoff_freq(cutoff_freq),
		.low_pass(low_pass), .out_valid(out_valid), .out_ready(out_ready),
		.den0(den0), .den1(den1), .den2(den2), .num0(num0), .num1(num1),
		.num2(num2)
	);

	// sample results and count cycles without progress
	always @(posedge clk) begin
		coeff_set_t r;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				r.d0 = den0; r.d1 = den1; r.d2 = den2;
				r.n0 = num0; r.n1 = num1; r.n2 = num2;
				sb.check_result(r);
			end
			if ((out_valid && out_ready) || (in_valid && in_ready))
				stalled_cycles <= 0;
			else
				stalled_cycles <= stalled_cycles + 1;
		end
	end

	always @(negedge clk)
		out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		if (stalled_cycles >= WATCHDOG) begin
			$display("watchdog expired after %0d idle cycles", WATCHDOG);
			$display("status: fail");
			$finish;
		end
	end

	// called at a falling edge; returns at the falling edge after the accept
	task automatic send_item(logic [RATE_W-1:0] f, logic lp);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		cutoff_freq <= f;
		low_pass <= lp;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_input(f, lp);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic set_rate(logic [RATE_W-1:0] r);
		@(negedge clk);
		cfg_we <= 1;
		cfg_wdata <= r;
		@(negedge clk);
		cfg_we <= 0;
		sb.rate = r;
	endtask

	task automatic random_item(logic [RATE_W-1:0] rate);
		logic [RATE_W-1:0] f;
		case ($urandom_range(3))
			0: f = 18'($urandom);
			1: f = (rate == 0) ? 18'd0 : 18'($urandom_range(rate - 1));
			2: f = 18'($urandom_range(30000));
			default: f = (rate == 0) ? 18'd1 : 18'(rate / 4 + $urandom_range(2) - 1);
		endcase
		send_item(f, 1'($urandom_range(1)));
	endtask

	initial begin
		logic [RATE_W-1:0] rates [0:6];
		sb = new();
		rates = '{18'd48000, 18'd1, 18'd262143, 18'd44100, 18'd0, 18'd8000,
			18'd96000};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// reset rate: extremes, quarter/half turn, wrap and alias
		send_item(0, 1); send_item(0, 0);
		send_item(18'h3FFFF, 1); send_item(18'h3FFFF, 0);
		send_item(12000, 1); send_item(12000, 0);
		send_item(24000, 1); send_item(24000, 0);
		send_item(36000, 1); send_item(47999, 0);
		send_item(48000, 1); send_item(48001, 0);
		send_item(30000, 1); send_item(1000, 0);
		send_item(18'h2AAAA, 1); send_item(18'h15555, 0);
		drain();
		set_rate(0);
		send_item(1000, 1); send_item(18'h3FFFF, 0);
		drain();
		set_rate(18'h3FFFF);
		send_item(18'h3FFFF, 1); send_item(18'h3FFFE, 0); send_item(65536, 1);
		drain();

		// one long receiver hold-off so the pipe fills and in_ready drops
		set_rate(48000);
		hold_off = 1;
		fork
			begin
				repeat (200) @(posedge clk);
				hold_off = 0;
			end
			repeat (90) random_item(48000);
		join
		drain();

		for (int ph = 0; ph < 7; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 75; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 75; end
				default: begin send_idle_pct = 34; recv_stall_pct = 34; end
			endcase
			set_rate(rates[ph]);
			repeat (135) random_item(rates[ph]);
			drain();
		end

		$display("sent %0d cutoff items over 7 sample rates incl. 0, 1 and max;", items_sent);
		$display("checked %0d coefficient sets under idle/stall mixes", sb.checked);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule

// ----- sim.f -----
design/bqc_pkg.sv
design/bqc_div_cell.sv
design/bqc_cordic_cell.sv
design/biquad_coefficient_calculator.sv
tb/sv/biquad_coefficient_calculator_tb.sv
